// ===== hw/rtl/command_line_tokenizer_top_defines.svh =====
// Assertion macros for the command line tokenizer.
`ifndef COMMAND_LINE_TOKENIZER_TOP_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_TOP_DEFINES_SVH

`ifndef SYNTH

// Checked out of reset only.
`define CLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define CLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CLT_ASSERT(lbl, prop, msg)
`define CLT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== hw/rtl/clt_pkg.sv =====
`timescale 1ns / 1ps

package clt_pkg;

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_NAME = 3'd1,
    PH_GAP  = 3'd2,
    PH_ARG  = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNul   = 8'h00;

  function automatic logic is_sep(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

endpackage

// ===== hw/rtl/clt_in_if.sv =====
`timescale 1ns / 1ps

interface clt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== hw/rtl/clt_out_if.sv =====
`timescale 1ns / 1ps

interface clt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       token_start;
  logic [3:0] token_index;
  logic [7:0] byte_offset;
  logic [3:0] arg_total;
  logic [7:0] name_offset;
  logic       out_last;

  modport source (
    output valid, output out_byte, output token_start, output token_index,
    output byte_offset, output arg_total, output name_offset, output out_last,
    input ready
  );
  modport sink (
    input valid, input out_byte, input token_start, input token_index,
    input byte_offset, input arg_total, input name_offset, input out_last,
    output ready
  );
endinterface

// ===== hw/rtl/command_line_tokenizer_top.sv =====
// Channel | Dir | Beat payload
// rx      | in  | in_byte, in_last
// tx      | out | out_byte, token_start, token_index, byte_offset, arg_total,
//         |     | name_offset, out_last
//
// One byte per cycle while tx is not stalled; each beat appears on tx in the cycle after its rx accept.
// Parse state updates in the accept cycle; results sit in the tx register.
// rx.ready is high while the tx register is empty or being drained.
// rst (synchronous) empties tx and starts a new buffer.
`timescale 1ns / 1ps
`include "command_line_tokenizer_top_defines.svh"

module command_line_tokenizer_top
  import clt_pkg::*;
#(
  parameter int BUFFER_SIZE = 64,
  parameter int MAX_ARGS    = 8
) (
  input  logic      clk,
  input  logic      rst,
  clt_in_if.sink    rx,
  clt_out_if.source tx
);

  localparam logic [7:0] NoneOff = 8'((BUFFER_SIZE > 255) ? 255 : BUFFER_SIZE);
  localparam logic [8:0] BufSize = 9'(BUFFER_SIZE);
  localparam logic [3:0] MaxArgs = 4'(MAX_ARGS);

  phase_t     phase, phase_next;
  logic [7:0] position;
  logic [3:0] arg_counter, arg_counter_next;
  logic [7:0] name_start, name_start_next;

  logic       accept;
  logic       sep, nul, last_eff;
  logic [7:0] ob;
  logic       start;
  logic [3:0] tix;
  logic [7:0] noff;

  assign rx.ready = !tx.valid || tx.ready;
  assign accept   = rx.valid && rx.ready;
  assign sep      = is_sep(rx.in_byte);
  assign nul      = (rx.in_byte == ChNul);
  assign last_eff = rx.in_last || (({1'b0, position} + 9'd1) >= BufSize);

  always_comb begin
    phase_next       = phase;
    arg_counter_next = arg_counter;
    name_start_next  = name_start;
    case (phase)
      PH_LEAD: begin
        if (!sep) begin
          name_start_next = position;
          phase_next      = nul ? PH_DONE : PH_NAME;
        end
      end
      PH_NAME: begin
        if (nul) phase_next = PH_DONE;
        else if (sep) phase_next = PH_GAP;
      end
      PH_GAP: begin
        if (nul) begin
          phase_next = PH_DONE;
        end else if (!sep) begin
          if (arg_counter < MaxArgs) begin
            arg_counter_next = arg_counter + 4'd1;
            phase_next       = PH_ARG;
          end else begin
            phase_next = PH_DONE;
          end
        end
      end
      PH_ARG: begin
        if (nul) phase_next = PH_DONE;
        else if (sep) phase_next = (arg_counter >= MaxArgs) ? PH_DONE : PH_GAP;
      end
      PH_DONE: phase_next = PH_DONE;
      default: phase_next = PH_DONE;
    endcase
  end

  always_comb begin
    ob    = rx.in_byte;
    start = 1'b0;
    tix   = 4'd0;
    case (phase)
      PH_LEAD: start = !sep && !nul;
      PH_NAME: if (sep) ob = ChNul;
      PH_GAP: begin
        if (!sep && !nul && (arg_counter < MaxArgs)) begin
          start = 1'b1;
          tix   = arg_counter + 4'd1;
        end
      end
      PH_ARG: if (sep) ob = ChNul;
      PH_DONE: ob = rx.in_byte;
      default: ob = rx.in_byte;
    endcase
    noff = (phase_next == PH_LEAD) ? NoneOff : name_start_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEAD;
      position    <= 8'd0;
      arg_counter <= 4'd0;
      name_start  <= 8'd0;
    end else if (accept) begin
      if (last_eff) begin
        phase       <= PH_LEAD;
        position    <= 8'd0;
        arg_counter <= 4'd0;
        name_start  <= 8'd0;
      end else begin
        phase       <= phase_next;
        position    <= position + 8'd1;
        arg_counter <= arg_counter_next;
        name_start  <= name_start_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (accept) begin
      tx.valid <= 1'b1;
    end else if (tx.ready) begin
      tx.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx.out_byte    <= ob;
      tx.token_start <= start;
      tx.token_index <= tix;
      tx.byte_offset <= position;
      tx.arg_total   <= arg_counter_next;
      tx.name_offset <= noff;
      tx.out_last    <= last_eff;
    end
  end

  `CLT_ASSERT(a_start_is_char, tx.valid && tx.token_start |-> tx.out_byte != ChNul && tx.out_byte != ChSpace && tx.out_byte != ChTab, "token start on a separator or NUL")
  `CLT_ASSERT(a_index_zero, tx.valid && !tx.token_start |-> tx.token_index == 4'd0, "token index set without token start")
  `CLT_ASSERT(a_args_bound, tx.valid |-> tx.arg_total <= MaxArgs, "argument count above limit")
  `CLT_ASSERT(a_offset_bound, tx.valid |-> {1'b0, tx.byte_offset} < BufSize, "byte offset outside buffer")
  `CLT_ASSERT(a_last_restart, accept && last_eff |=> position == 8'd0 && phase == PH_LEAD && arg_counter == 4'd0, "state not restarted after last beat")
  `CLT_ASSERT_ALWAYS(a_reset_empty, rst |=> !tx.valid, "tx valid after reset")

endmodule

// ===== tb/command_line_tokenizer_checker.sv =====
`timescale 1ns / 1ps

module command_line_tokenizer_checker
  import clt_pkg::*;
#(
  parameter int BUFFER_SIZE = 64,
  parameter int MAX_ARGS    = 8
) (
  input  logic clk,
  input  logic rst,
  clt_in_if    rx,
  clt_out_if   tx,
  output int   mismatches,
  output int   outstanding,
  output int   starts_seen,
  output int   buffers_seen,
  output int   limit_hits
);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       token_start;
    logic [3:0] token_index;
    logic [7:0] byte_offset;
    logic [3:0] arg_total;
    logic [7:0] name_offset;
    logic       out_last;
  } beat_t;

  localparam logic [7:0] NoNameOffset = (BUFFER_SIZE > 255) ? 8'd255 : 8'(BUFFER_SIZE);

  phase_t     phase_q  = PH_LEAD;
  logic [7:0] pos_q    = '0;
  logic [3:0] args_q   = '0;
  logic [7:0] name_q   = '0;
  beat_t      expected_beats[$];
  int         fail_total  = 0;
  int         result_no   = 0;
  int         start_total = 0;
  int         last_total  = 0;
  int         limit_total = 0;

  function automatic void clear_parse();
    phase_q = PH_LEAD;
    pos_q   = '0;
    args_q  = '0;
    name_q  = '0;
  endfunction

  function automatic beat_t tokenize_byte(input logic [7:0] b, input logic last_in);
    beat_t r;
    logic  blank;
    blank         = (b == ChSpace) || (b == ChTab);
    r.out_byte    = b;
    r.token_start = 1'b0;
    r.token_index = '0;
    r.byte_offset = pos_q;
    case (phase_q)
      PH_LEAD: begin
        if (!blank) begin
          name_q = pos_q;
          if (b == ChNul) begin
            phase_q = PH_DONE;
          end else begin
            r.token_start = 1'b1;
            phase_q       = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        if (b == ChNul) begin
          phase_q = PH_DONE;
        end else if (blank) begin
          r.out_byte = ChNul;
          phase_q    = PH_GAP;
        end
      end
      PH_GAP: begin
        if (b == ChNul) begin
          phase_q = PH_DONE;
        end else if (!blank) begin
          if (args_q < MAX_ARGS) begin
            args_q        = args_q + 4'd1;
            r.token_start = 1'b1;
            r.token_index = args_q;
            phase_q       = PH_ARG;
          end else begin
            phase_q = PH_DONE;
          end
        end
      end
      PH_ARG: begin
        if (b == ChNul) begin
          phase_q = PH_DONE;
        end else if (blank) begin
          r.out_byte = ChNul;
          if (args_q >= MAX_ARGS) begin
            phase_q = PH_DONE;
            limit_total++;
          end else begin
            phase_q = PH_GAP;
          end
        end
      end
      default: phase_q = PH_DONE;
    endcase
    r.arg_total   = args_q;
    r.name_offset = (phase_q == PH_LEAD) ? NoNameOffset : name_q;
    r.out_last    = last_in || (int'(pos_q) + 1 >= BUFFER_SIZE);
    if (r.token_start) start_total++;
    if (r.out_last) begin
      last_total++;
      clear_parse();
    end else begin
      pos_q = pos_q + 8'd1;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    fail_total++;
    $display("MISMATCH at result %0d: %s", result_no, msg);
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin : monitor
    beat_t want;
    if (rst) begin
      clear_parse();
      expected_beats.delete();
    end else begin
      if (tx.valid && tx.ready) begin
        if (expected_beats.size() == 0) begin
          flag_mismatch("result beat with nothing expected");
        end else begin
          want = expected_beats.pop_front();
          compare_field("out_byte", tx.out_byte, want.out_byte);
          compare_field("token_start", 8'(tx.token_start), 8'(want.token_start));
          compare_field("token_index", 8'(tx.token_index), 8'(want.token_index));
          compare_field("byte_offset", tx.byte_offset, want.byte_offset);
          compare_field("arg_total", 8'(tx.arg_total), 8'(want.arg_total));
          compare_field("name_offset", tx.name_offset, want.name_offset);
          compare_field("out_last", 8'(tx.out_last), 8'(want.out_last));
        end
        result_no++;
      end
      if (rx.valid && rx.ready) expected_beats.push_back(tokenize_byte(rx.in_byte, rx.in_last));
    end
    mismatches   <= fail_total;
    outstanding  <= expected_beats.size();
    starts_seen  <= start_total;
    buffers_seen <= last_total;
    limit_hits   <= limit_total;
  end

endmodule

// ===== tb/tb_command_line_tokenizer_top.sv =====
`timescale 1ns / 1ps

module tb_command_line_tokenizer_top;
  import clt_pkg::*;

  localparam int BUFFER_SIZE   = 64;
  localparam int MAX_ARGS      = 8;
  localparam int ByteTarget    = 1250;
  localparam int QuietFrom     = 1050;
  localparam int WatchdogLimit = 2000;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       sink_ready = 1'b0;
  bit         quiet      = 1'b0;
  int         stall_left = 0;
  int         idle_cycles = 0;
  int         bytes_sent = 0;
  int         line_len   = 0;
  logic [7:0] line_buf[BUFFER_SIZE];
  int         mismatches, outstanding, starts_seen, buffers_seen, limit_hits;

  clt_in_if  rx ();
  clt_out_if tx ();

  assign tx.ready = sink_ready;

  command_line_tokenizer_top #(
    .BUFFER_SIZE(BUFFER_SIZE),
    .MAX_ARGS   (MAX_ARGS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .rx (rx),
    .tx (tx)
  );

  command_line_tokenizer_checker #(
    .BUFFER_SIZE(BUFFER_SIZE),
    .MAX_ARGS   (MAX_ARGS)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx),
    .tx          (tx),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .starts_seen (starts_seen),
    .buffers_seen(buffers_seen),
    .limit_hits  (limit_hits)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 9);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((rx.valid && rx.ready) || (tx.valid && tx.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Timeout: no beat on either channel for %0d cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void add_char(input logic [7:0] c);
    if (line_len < BUFFER_SIZE) begin
      line_buf[line_len] = c;
      line_len++;
    end
  endfunction

  function automatic logic [7:0] blank_char();
    return ($urandom_range(0, 1) == 0) ? ChSpace : ChTab;
  endfunction

  function automatic logic [7:0] token_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == ChSpace || c == ChTab);
    return c;
  endfunction

  function automatic void compose_command(input int ntok, input bit nul_end);
    line_len = 0;
    repeat ($urandom_range(0, 3)) add_char(blank_char());
    for (int t = 0; t < ntok; t++) begin
      if (t > 0) repeat ($urandom_range(1, 3)) add_char(blank_char());
      repeat ($urandom_range(1, 6)) add_char(token_char());
    end
    repeat ($urandom_range(0, 2)) add_char(blank_char());
    if (nul_end) add_char(ChNul);
    repeat ($urandom_range(0, 4)) add_char(8'($urandom_range(0, 255)));
  endfunction

  function automatic void compose_noise();
    int n;
    n        = $urandom_range(1, BUFFER_SIZE);
    line_len = 0;
    repeat (n) begin
      case ($urandom_range(0, 7))
        0:       add_char(ChSpace);
        1:       add_char(ChTab);
        2:       add_char(ChNul);
        default: add_char(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last_flag);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      rx.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.in_byte <= b;
    rx.in_last <= last_flag;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_line(input bit final_flag);
    for (int i = 0; i < line_len; i++) push_byte(line_buf[i], final_flag && (i == line_len - 1));
  endtask

  task automatic drain();
    rx.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    bit paused;
    bit final_flag;
    paused     = 1'b0;
    rx.valid   <= 1'b0;
    rx.in_byte <= '0;
    rx.in_last <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // NUL before any name
    line_len = 0;
    add_char(ChNul);
    send_line(1'b1);
    // blanks only
    line_len = 0;
    add_char(ChSpace);
    add_char(ChTab);
    add_char(ChSpace);
    send_line(1'b1);
    // tab ends the name, NUL inside an argument, byte passes after
    line_len = 0;
    add_char(8'hFF);
    add_char(ChTab);
    add_char(8'h01);
    add_char(ChNul);
    add_char(8'h7F);
    send_line(1'b1);
    // name plus every argument slot, separator after the last one
    line_len = 0;
    for (int k = 0; k <= MAX_ARGS; k++) begin
      add_char(8'h61 + 8'(k));
      add_char((k % 2 == 0) ? ChSpace : ChTab);
    end
    send_line(1'b1);
    drain();

    while (bytes_sent < ByteTarget) begin
      if (bytes_sent >= QuietFrom) quiet <= 1'b1;
      if (!paused && bytes_sent >= ByteTarget / 2) begin
        paused = 1'b1;
        drain();
      end
      if ($urandom_range(0, 3) != 0) compose_command($urandom_range(1, MAX_ARGS + 3),
                                                     1'($urandom_range(0, 1)));
      else compose_noise();
      if (line_len == BUFFER_SIZE) final_flag = 1'($urandom_range(0, 1));
      else final_flag = ($urandom_range(0, 9) != 0);
      send_line(final_flag);
    end

    drain();
    repeat (4) @(posedge clk);
    $display("Sent %0d bytes closing %0d buffers, %0d token starts marked",
             bytes_sent, buffers_seen, starts_seen);
    $display("Argument limit hit in %0d buffers; random stalls on both channels",
             limit_hits);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
